// File: sv/uyvy_tpg_pkg.sv
// shared types, codes, constants and helper functions of the uyvy test pattern generator
package uyvy_tpg_pkg;

    // field widths
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int BYTE_W     = 8;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // pattern modes
    localparam logic [1:0] MODE_BARS    = 2'd0;
    localparam logic [1:0] MODE_BLACK   = 2'd1;
    localparam logic [1:0] MODE_WHITE   = 2'd2;
    localparam logic [1:0] MODE_CHECKER = 2'd3;

    // reset geometry
    localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd1920;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd1080;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // colour codes; bar codes 0..7 follow the bar order, bar 7 is black
    typedef logic [3:0] t_color;
    localparam t_color COL_BAR0   = 4'd0;
    localparam t_color COL_BAR1   = 4'd1;
    localparam t_color COL_BAR2   = 4'd2;
    localparam t_color COL_BAR3   = 4'd3;
    localparam t_color COL_BAR4   = 4'd4;
    localparam t_color COL_BAR5   = 4'd5;
    localparam t_color COL_BAR6   = 4'd6;
    localparam t_color COL_BLACK  = 4'd7;
    localparam t_color COL_WHITE  = 4'd8;
    localparam t_color COL_GRAY   = 4'd9;
    localparam t_color COL_BELOW  = 4'd10;
    localparam t_color COL_ABOVE  = 4'd11;

    typedef struct packed {
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] u;
        logic [BYTE_W-1:0] v;
    } t_yuv;

    // per-width thresholds, derived when the width register is written
    typedef struct packed {
        logic [7:1][THR_W-1:0] bar_thr;   // k * w, bar boundary when 8x >= k*w
        logic [6:1][THR_W-1:0] plu_thr;   // k * w, pluge boundary when 7x >= k*w
        logic [DIM_W-1:0]      quarter;
        logic [DIM_W-1:0]      half;
        logic [DIM_W-1:0]      three_q;
    } t_wgeom;

    // per-height row boundaries
    typedef struct packed {
        logic [DIM_W-1:0] top_end;
        logic [DIM_W-1:0] mid_end;
    } t_hgeom;

    function automatic t_wgeom width_geom(input logic [DIM_W-1:0] w);
        t_wgeom g;
        logic [THR_W-1:0] w_ext;
        logic [THR_W-1:0] w3;
        w_ext = THR_W'(w);
        w3    = (w_ext << 1) + w_ext;
        for (int k = 1; k <= 7; k++) begin
            g.bar_thr[k] = THR_W'(w_ext * THR_W'(k));
        end
        for (int k = 1; k <= 6; k++) begin
            g.plu_thr[k] = THR_W'(w_ext * THR_W'(k));
        end
        g.quarter = w >> 2;
        g.half    = w >> 1;
        g.three_q = w3[DIM_W+1:2];
        return g;
    endfunction

    function automatic t_hgeom height_geom(input logic [DIM_W-1:0] h);
        t_hgeom g;
        logic [DIM_W+1:0] h3;
        h3        = ((DIM_W+2)'(h) << 1) + (DIM_W+2)'(h);
        g.top_end = h3[DIM_W+1:2];
        g.mid_end = g.top_end + (h >> 3);
        return g;
    endfunction

    function automatic t_yuv color_lookup(input t_color c);
        t_yuv r;
        case (c)
            COL_BAR0:  r = '{y: 8'd180, u: 8'd128, v: 8'd128};
            COL_BAR1:  r = '{y: 8'd162, u: 8'd44,  v: 8'd142};
            COL_BAR2:  r = '{y: 8'd131, u: 8'd156, v: 8'd44};
            COL_BAR3:  r = '{y: 8'd112, u: 8'd72,  v: 8'd58};
            COL_BAR4:  r = '{y: 8'd84,  u: 8'd184, v: 8'd198};
            COL_BAR5:  r = '{y: 8'd65,  u: 8'd100, v: 8'd212};
            COL_BAR6:  r = '{y: 8'd35,  u: 8'd212, v: 8'd114};
            COL_BLACK: r = '{y: 8'd16,  u: 8'd128, v: 8'd128};
            COL_WHITE: r = '{y: 8'd235, u: 8'd128, v: 8'd128};
            COL_GRAY:  r = '{y: 8'd128, u: 8'd128, v: 8'd128};
            COL_BELOW: r = '{y: 8'd4,   u: 8'd128, v: 8'd128};
            COL_ABOVE: r = '{y: 8'd20,  u: 8'd128, v: 8'd128};
            default:   r = '{y: 8'd16,  u: 8'd128, v: 8'd128};
        endcase
        return r;
    endfunction

endpackage

// File: sv/uyvy_tpg_cfg.sv
// configuration registers with frame geometry derived at write time
module uyvy_tpg_cfg #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [uyvy_tpg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [uyvy_tpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [1:0]                          o_mode,
    output uyvy_tpg_pkg::t_wgeom                o_wgeom,
    output uyvy_tpg_pkg::t_hgeom                o_hgeom
);
    import uyvy_tpg_pkg::*;

    logic [1:0] r_mode;
    t_wgeom     r_wgeom;
    t_hgeom     r_hgeom;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W:0] lim;
        lim = (DIM_W+1)'(MAX_DIMENSION);
        return ({1'b0, d} > lim) ? lim[DIM_W-1:0] : d;
    endfunction

    function automatic logic [DIM_W-1:0] fix_width(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] c;
        c = clamp_dim(d);
        return (c == '0) ? DIM_W'(1) : c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BARS;
            r_wgeom <= width_geom(fix_width(RST_WIDTH));
            r_hgeom <= height_geom(clamp_dim(RST_HEIGHT));
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:   r_mode  <= i_cfg_data[1:0];
                REG_WIDTH:  r_wgeom <= width_geom(fix_width(i_cfg_data));
                REG_HEIGHT: r_hgeom <= height_geom(clamp_dim(i_cfg_data));
                default: ;
            endcase
        end
    end

    assign o_mode  = r_mode;
    assign o_wgeom = r_wgeom;
    assign o_hgeom = r_hgeom;

endmodule

// File: sv/uyvy_tpg_front.sv
// front end: accepts a pixel pair address and classifies it into a colour code
module uyvy_tpg_front #(
    parameter int SQUARE_SIZE = 64
) (
    input  logic                             i_valid,
    input  logic                             i_queue_full,
    input  logic [uyvy_tpg_pkg::COORD_W-1:0] i_column,
    input  logic [uyvy_tpg_pkg::COORD_W-1:0] i_row,
    input  logic [1:0]                       i_mode,
    input  uyvy_tpg_pkg::t_wgeom             i_wgeom,
    input  uyvy_tpg_pkg::t_hgeom             i_hgeom,
    output logic                             o_stall,
    output logic                             o_push,
    output uyvy_tpg_pkg::t_color             o_color
);
    import uyvy_tpg_pkg::*;

    // floor(v / SQUARE_SIZE) == (v * RECIP) >> SHIFT, exact for 12-bit v
    localparam int SQ_LOG = $clog2(SQUARE_SIZE);
    localparam int SHIFT  = COORD_W + SQ_LOG;
    localparam int RECIP  = ((1 << SHIFT) + SQUARE_SIZE - 1) / SQUARE_SIZE;
    localparam int RCP_W  = COORD_W + 2;
    localparam int PROD_W = COORD_W + RCP_W;

    logic [COORD_W-1:0] x;
    logic [THR_W-1:0]   x8;
    logic [THR_W-1:0]   x7;
    logic [2:0]         bar_idx;
    logic [2:0]         plu_sec;
    logic [PROD_W-1:0]  qx_prod;
    logic [PROD_W-1:0]  qy_prod;
    logic               checker_odd;
    t_color             bar_color;
    t_color             mid_color;
    t_color             plu_color;

    assign x  = {i_column[COORD_W-1:1], 1'b0};
    assign x8 = THR_W'(x) << 3;
    assign x7 = (THR_W'(x) << 3) - THR_W'(x);

    // thresholds are monotonic, so the count of crossed ones is the section index
    always_comb begin
        bar_idx = '0;
        for (int k = 1; k <= 7; k++) begin
            bar_idx = bar_idx + 3'(x8 >= i_wgeom.bar_thr[k]);
        end
        plu_sec = '0;
        for (int k = 1; k <= 6; k++) begin
            plu_sec = plu_sec + 3'(x7 >= i_wgeom.plu_thr[k]);
        end
    end

    assign bar_color = t_color'(bar_idx);

    always_comb begin
        if (DIM_W'(x) < i_wgeom.quarter) begin
            mid_color = COL_BLACK;
        end else if (DIM_W'(x) < i_wgeom.half) begin
            mid_color = COL_WHITE;
        end else if (DIM_W'(x) < i_wgeom.three_q) begin
            mid_color = COL_BLACK;
        end else begin
            mid_color = COL_GRAY;
        end
    end

    always_comb begin
        case (plu_sec)
            3'd2:    plu_color = COL_GRAY;
            3'd4:    plu_color = COL_BELOW;
            3'd0, 3'd1, 3'd3, 3'd5: plu_color = COL_BLACK;
            default: plu_color = COL_ABOVE;
        endcase
    end

    assign qx_prod     = PROD_W'(x) * PROD_W'(RECIP);
    assign qy_prod     = PROD_W'(i_row) * PROD_W'(RECIP);
    assign checker_odd = qx_prod[SHIFT] ^ qy_prod[SHIFT];

    always_comb begin
        case (i_mode)
            MODE_BARS: begin
                if (DIM_W'(i_row) < i_hgeom.top_end) begin
                    o_color = bar_color;
                end else if (DIM_W'(i_row) < i_hgeom.mid_end) begin
                    o_color = mid_color;
                end else begin
                    o_color = plu_color;
                end
            end
            MODE_BLACK:   o_color = COL_BLACK;
            MODE_WHITE:   o_color = COL_WHITE;
            MODE_CHECKER: o_color = checker_odd ? COL_BLACK : COL_WHITE;
            default:      o_color = COL_BLACK;
        endcase
    end

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

endmodule

// File: sv/uyvy_tpg_queue.sv
// short queue of colour codes between front and back
module uyvy_tpg_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  uyvy_tpg_pkg::t_color i_color,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_not_empty,
    output uyvy_tpg_pkg::t_color o_color
);
    import uyvy_tpg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_color             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? bump(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? bump(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_color;
        end
    end

    assign o_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_color     = r_mem[r_rd_ptr];

endmodule

// File: sv/uyvy_tpg_back.sv
// back end: turns a colour code into the uyvy word and holds it in the output register
module uyvy_tpg_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_queue_not_empty,
    input  uyvy_tpg_pkg::t_color            i_color,
    input  logic                            i_stall,
    output logic                            o_pop,
    output logic                            o_valid,
    output logic [uyvy_tpg_pkg::BYTE_W-1:0] o_chroma_u,
    output logic [uyvy_tpg_pkg::BYTE_W-1:0] o_luma_first,
    output logic [uyvy_tpg_pkg::BYTE_W-1:0] o_chroma_v,
    output logic [uyvy_tpg_pkg::BYTE_W-1:0] o_luma_second
);
    import uyvy_tpg_pkg::*;

    logic r_valid;
    logic n_valid;
    t_yuv r_yuv;
    logic out_free;

    assign out_free = !r_valid || !i_stall;
    assign o_pop    = i_queue_not_empty && out_free;
    assign n_valid  = out_free ? i_queue_not_empty : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_yuv <= color_lookup(i_color);
        end
    end

    assign o_valid       = r_valid;
    assign o_chroma_u    = r_yuv.u;
    assign o_luma_first  = r_yuv.y;
    assign o_chroma_v    = r_yuv.v;
    assign o_luma_second = r_yuv.y;

endmodule

// File: sv/uyvy_test_pattern_generator.sv
// top level of the uyvy test pattern generator
//
// Returns one UYVY word (U, Y0, V, Y1) per pixel pair address (even column, row) for the
// selected pattern: 75% colour bars with a middle strip and a pluge strip, a black frame,
// a white frame, or a checkerboard of SQUARE_SIZE squares. Both pixels of a pair share one
// colour and bit 0 of the column is ignored. While the output is not stalled, throughput is
// one word per clock with no gaps: the front end classifies an address into a colour code
// in the cycle it is accepted, the code goes into a two-word queue, and the back end looks
// the code up into the output register. A word accepted at one edge is shown on the output
// from the next edge on. Input stall rises only when the queue is full, i.e. after the output
// has been stalled for two words. Configuration (pattern mode, frame width, frame height) is
// written through the plain write port while the block is idle, which the user must ensure;
// the block does not enforce it. Width and height thresholds are derived at the write edge,
// dimensions above MAX_DIMENSION saturate, a zero width is 1, writes to index 3 are ignored.
module uyvy_test_pattern_generator #(
    parameter int SQUARE_SIZE   = 64,
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [uyvy_tpg_pkg::COORD_W-1:0]    i_column,
    input  logic [uyvy_tpg_pkg::COORD_W-1:0]    i_row,
    // output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [uyvy_tpg_pkg::BYTE_W-1:0]     o_chroma_u,
    output logic [uyvy_tpg_pkg::BYTE_W-1:0]     o_luma_first,
    output logic [uyvy_tpg_pkg::BYTE_W-1:0]     o_chroma_v,
    output logic [uyvy_tpg_pkg::BYTE_W-1:0]     o_luma_second,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [uyvy_tpg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [uyvy_tpg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import uyvy_tpg_pkg::*;

    logic   [1:0] mode;
    t_wgeom       wgeom;
    t_hgeom       hgeom;
    logic         queue_full;
    logic         queue_not_empty;
    logic         push;
    logic         pop;
    t_color       front_color;
    t_color       queue_color;

    // register file, geometry thresholds precomputed per write
    uyvy_tpg_cfg #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_mode     (mode),
        .o_wgeom    (wgeom),
        .o_hgeom    (hgeom)
    );

    // address classification, one word per cycle while the queue is not full
    uyvy_tpg_front #(
        .SQUARE_SIZE(SQUARE_SIZE)
    ) u_front (
        .i_valid     (i_valid),
        .i_queue_full(queue_full),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_mode      (mode),
        .i_wgeom     (wgeom),
        .i_hgeom     (hgeom),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_color     (front_color)
    );

    // decouples the input handshake from output stalls
    uyvy_tpg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_color    (front_color),
        .i_pop      (pop),
        .o_full     (queue_full),
        .o_not_empty(queue_not_empty),
        .o_color    (queue_color)
    );

    // colour lookup into the output register
    uyvy_tpg_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_queue_not_empty(queue_not_empty),
        .i_color          (queue_color),
        .i_stall          (i_stall),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .o_chroma_u       (o_chroma_u),
        .o_luma_first     (o_luma_first),
        .o_chroma_v       (o_chroma_v),
        .o_luma_second    (o_luma_second)
    );

endmodule

// File: sv/uyvy_tpg_checker.sv
// port-level checker of the uyvy test pattern generator and its bind
module uyvy_tpg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_chroma_u,
    input logic [7:0] o_luma_first,
    input logic [7:0] o_chroma_v,
    input logic [7:0] o_luma_second
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_chroma_u) && $stable(o_luma_first)
            && $stable(o_chroma_v) && $stable(o_luma_second))
        else $error("output word changed while stalled");

    // both pixels of a pair share one luma
    a_pair_luma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_luma_first == o_luma_second)
        else $error("pair luma mismatch");

    // only colour bars carry chroma other than neutral
    a_bar_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_chroma_u != 8'd128 || o_chroma_v != 8'd128) |->
            o_luma_first == 8'd162 || o_luma_first == 8'd131 || o_luma_first == 8'd112 ||
            o_luma_first == 8'd84 || o_luma_first == 8'd65 || o_luma_first == 8'd35)
        else $error("chroma on a grey level");

    // reset empties the queue and the output register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");

endmodule

bind uyvy_test_pattern_generator uyvy_tpg_checker u_tpg_checker (.*);

// File: verif/tb.sv
// self-checking testbench of the uyvy test pattern generator
`timescale 1ns / 1ps

module tb;
    import uyvy_tpg_pkg::*;

    localparam int SQUARE_SIZE   = 64;
    localparam int MAX_DIMENSION = 4096;

    // index past the last register, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // grey levels and neutral chroma
    localparam logic [BYTE_W-1:0] LUMA_BLACK  = 8'd16;
    localparam logic [BYTE_W-1:0] LUMA_WHITE  = 8'd235;
    localparam logic [BYTE_W-1:0] LUMA_GRAY   = 8'd128;
    localparam logic [BYTE_W-1:0] LUMA_BELOW  = 8'd4;
    localparam logic [BYTE_W-1:0] LUMA_ABOVE  = 8'd20;
    localparam logic [BYTE_W-1:0] CHROMA_MID  = 8'd128;

    localparam int PHASES         = 16;
    localparam int WORDS_PER_PASS = 50;
    localparam int HOLD_CYCLES    = 40;
    localparam int DRAIN_CYCLES   = 4;
    localparam int CYCLE_LIMIT    = 200000;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_pixel_pair;

    typedef struct packed {
        logic [BYTE_W-1:0] chroma_u;
        logic [BYTE_W-1:0] luma_first;
        logic [BYTE_W-1:0] chroma_v;
        logic [BYTE_W-1:0] luma_second;
    } t_uyvy_word;

    // dut ports, every input known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic [COORD_W-1:0]    i_column      = '0;
    logic [COORD_W-1:0]    i_row         = '0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic [BYTE_W-1:0]     o_chroma_u;
    logic [BYTE_W-1:0]     o_luma_first;
    logic [BYTE_W-1:0]     o_chroma_v;
    logic [BYTE_W-1:0]     o_luma_second;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // local copy of the register file, follows every write
    logic [1:0]       cfg_mode   = MODE_BARS;
    logic [DIM_W-1:0] cfg_width  = RST_WIDTH;
    logic [DIM_W-1:0] cfg_height = RST_HEIGHT;

    t_pixel_pair pending_pairs[$];
    t_uyvy_word  expected_words[$];

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;

    // handshake events seen at the last rising edge
    bit pair_taken = 1'b0;
    bit word_taken = 1'b0;

    // idle bounds per pass, 0 gives a stretch without gaps
    int unsigned send_gap_max = 0;
    int unsigned recv_gap_max = 0;
    int unsigned send_wait    = 0;
    int unsigned recv_wait    = 0;

    // long receiver hold-off
    bit   hold_armed = 1'b0;
    logic recv_hold  = 1'b0;

    uyvy_test_pattern_generator #(
        .SQUARE_SIZE   (SQUARE_SIZE),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_column      (i_column),
        .i_row         (i_row),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_chroma_u    (o_chroma_u),
        .o_luma_first  (o_luma_first),
        .o_chroma_v    (o_chroma_v),
        .o_luma_second (o_luma_second),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // pattern prediction
    // ---------------------------------------------------------------

    // dimensions saturate at the maximum frame size
    function automatic int unsigned clamped_dim(input logic [DIM_W-1:0] d);
        return (d > MAX_DIMENSION) ? MAX_DIMENSION : int'(d);
    endfunction

    function automatic t_uyvy_word tone(input logic [BYTE_W-1:0] luma,
                                        input logic [BYTE_W-1:0] cb,
                                        input logic [BYTE_W-1:0] cr);
        return '{chroma_u: cb, luma_first: luma, chroma_v: cr, luma_second: luma};
    endfunction

    // 75% bars left to right, the last one black
    function automatic t_uyvy_word bar_tone(input int unsigned bar);
        case (bar)
            0:       return tone(8'd180, 8'd128, 8'd128);
            1:       return tone(8'd162, 8'd44,  8'd142);
            2:       return tone(8'd131, 8'd156, 8'd44);
            3:       return tone(8'd112, 8'd72,  8'd58);
            4:       return tone(8'd84,  8'd184, 8'd198);
            5:       return tone(8'd65,  8'd100, 8'd212);
            6:       return tone(8'd35,  8'd212, 8'd114);
            default: return tone(LUMA_BLACK, CHROMA_MID, CHROMA_MID);
        endcase
    endfunction

    // expected word for one pixel pair under the current registers
    function automatic t_uyvy_word pattern_word(input logic [COORD_W-1:0] column,
                                                input logic [COORD_W-1:0] row);
        int unsigned x;
        int unsigned y;
        int unsigned w;
        int unsigned h;
        int unsigned top_end;
        int unsigned mid_end;
        int unsigned bar;
        logic [BYTE_W-1:0] luma;
        x = column & 12'hFFE;    // pair address, bit 0 does not matter
        y = row;
        luma = LUMA_BLACK;
        case (cfg_mode)
            MODE_BARS: begin
                w = clamped_dim(cfg_width);
                h = clamped_dim(cfg_height);
                if (w == 0) begin
                    w = 1;
                end
                top_end = h * 3 / 4;
                mid_end = top_end + h / 8;
                if (y < top_end) begin
                    bar = x * 8 / w;
                    return bar_tone(bar > 7 ? 7 : bar);
                end
                if (y < mid_end) begin
                    // black, white, black, gray quarters
                    if (x < w / 4) begin
                        luma = LUMA_BLACK;
                    end else if (x < w / 2) begin
                        luma = LUMA_WHITE;
                    end else if (x < w * 3 / 4) begin
                        luma = LUMA_BLACK;
                    end else begin
                        luma = LUMA_GRAY;
                    end
                end else begin
                    // pluge strip, sections past the sixth stay at the upper level
                    case (x * 7 / w)
                        0, 1, 3, 5: luma = LUMA_BLACK;
                        2:          luma = LUMA_GRAY;
                        4:          luma = LUMA_BELOW;
                        default:    luma = LUMA_ABOVE;
                    endcase
                end
            end
            MODE_BLACK: luma = LUMA_BLACK;
            MODE_WHITE: luma = LUMA_WHITE;
            default: begin
                // checkerboard, white square at the top-left
                luma = (((x / SQUARE_SIZE) + (y / SQUARE_SIZE)) % 2 == 0) ?
                       LUMA_WHITE : LUMA_BLACK;
            end
        endcase
        return tone(luma, CHROMA_MID, CHROMA_MID);
    endfunction

    // ---------------------------------------------------------------
    // error reporting
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_byte(input string field, input logic [BYTE_W-1:0] got,
                              input logic [BYTE_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
        end
    endtask

    // ---------------------------------------------------------------
    // sampling at the rising edge: timeout, output check, prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : edge_sampler
        t_uyvy_word want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** uyvy_test_pattern_generator: FAILED **");
            $finish;
        end else begin
            pair_taken = i_rst_n && i_valid && !o_stall;
            word_taken = i_rst_n && o_valid && !i_stall;
            // the output word always belongs to an earlier pair, so check first
            if (word_taken) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("word with no pair waiting for it");
                end else begin
                    want = expected_words.pop_front();
                    check_byte("chroma_u",    o_chroma_u,    want.chroma_u);
                    check_byte("luma_first",  o_luma_first,  want.luma_first);
                    check_byte("chroma_v",    o_chroma_v,    want.chroma_v);
                    check_byte("luma_second", o_luma_second, want.luma_second);
                end
            end
            if (pair_taken) begin
                expected_words.push_back(pattern_word(i_column, i_row));
            end
        end
    end

    // ---------------------------------------------------------------
    // pair driver: falling edge, random gap before each pair
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : pair_driver
        t_pixel_pair next_pair;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !pair_taken) begin
            // stalled, hold the pair as it is
        end else if (send_wait > 0) begin
            send_wait--;
            i_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
            next_pair = pending_pairs.pop_front();
            i_column  <= next_pair.column;
            i_row     <= next_pair.row;
            i_valid   <= 1'b1;
            send_wait = $urandom_range(0, send_gap_max);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // word receiver: random stall after each taken word, plus the long hold
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : word_receiver
        if (word_taken) begin
            recv_wait = $urandom_range(0, recv_gap_max);
        end else if (recv_wait > 0) begin
            recv_wait--;
        end
        i_stall <= recv_hold || (recv_wait != 0);
    end

    // long hold-off, counted here while the driver keeps offering pairs
    initial begin : receiver_hold
        wait (hold_armed);
        @(negedge i_clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        recv_hold <= 1'b0;
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    task automatic queue_pair(input int unsigned column, input int unsigned row);
        t_pixel_pair pair;
        pair.column = COORD_W'(column);
        pair.row    = COORD_W'(row);
        pending_pairs.push_back(pair);
    endtask

    // block idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_for_drain();
        while (pending_pairs.size() != 0 || i_valid || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        case (index)
            REG_MODE:   cfg_mode   = value[1:0];
            REG_WIDTH:  cfg_width  = value;
            REG_HEIGHT: cfg_height = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int unsigned clip_coord(input int value);
        if (value < 0) begin
            return 0;
        end
        return (value > 4095) ? 4095 : value;
    endfunction

    // mix of full-range, in-frame and near-boundary pairs
    task automatic queue_random_pair();
        int unsigned w;
        int unsigned h;
        int unsigned span;
        int unsigned mark;
        int          column;
        int          row;
        w = clamped_dim(cfg_width);
        h = clamped_dim(cfg_height);
        if (w == 0) begin
            w = 1;
        end
        case ($urandom_range(0, 3))
            0: begin
                column = $urandom_range(0, 4095);
                row    = $urandom_range(0, 4095);
            end
            1: begin
                column = $urandom_range(0, (w > 4096 ? 4096 : w) - 1);
                row    = (h == 0) ? 0 : $urandom_range(0, h - 1);
            end
            default: begin
                // near bar, quarter, pluge or square boundaries
                case ($urandom_range(0, 3))
                    0:       span = 8;
                    1:       span = 7;
                    2:       span = 4;
                    default: span = 0;
                endcase
                mark   = $urandom_range(0, 8);
                column = (span == 0) ? mark * SQUARE_SIZE : mark * w / span;
                column = column + $urandom_range(0, 4) - 2;
                case ($urandom_range(0, 3))
                    0:       row = h * 3 / 4;
                    1:       row = h * 3 / 4 + h / 8;
                    2:       row = h;
                    default: row = $urandom_range(0, 8) * SQUARE_SIZE;
                endcase
                row = row + $urandom_range(0, 4) - 2;
            end
        endcase
        queue_pair(clip_coord(column), clip_coord(row));
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_width();
        case ($urandom_range(0, 6))
            0:       return 13'd2;
            1:       return 13'd4096;
            2:       return 13'd0;              // treated as one
            3:       return 13'd8191;           // saturates
            4:       return 13'(2 * $urandom_range(1, 32));
            default: return 13'(2 * $urandom_range(1, 2048));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height();
        case ($urandom_range(0, 6))
            0:       return 13'd1;
            1:       return 13'd4096;
            2:       return 13'd0;
            3:       return 13'd8191;
            4:       return 13'($urandom_range(1, 64));
            default: return 13'($urandom_range(1, 4096));
        endcase
    endfunction

    initial begin : stimulus
        logic [1:0]            mode;
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] height;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pairs at the reset geometry, 1920 x 1080 bars
        for (int bar = 0; bar < 8; bar++) begin
            queue_pair(bar * 240, 0);
        end
        for (int quarter = 0; quarter < 4; quarter++) begin
            queue_pair(quarter * 480, 810);    // middle strip
        end
        queue_pair(0,    1000);                // pluge sections
        queue_pair(276,  1000);
        queue_pair(552,  1000);
        queue_pair(824,  1000);
        queue_pair(1098, 1000);
        queue_pair(1372, 1000);
        queue_pair(1646, 1000);
        queue_pair(4094, 4095);                // far outside the frame
        queue_pair(4095, 0);                   // odd column, saturated bar
        queue_pair(1919, 809);                 // last in-frame pair of the bars
        wait_for_drain();

        // a write to the unused index must change nothing
        write_reg(REG_UNUSED, 13'($urandom_range(0, 8191)));

        for (int pass = 0; pass < PHASES; pass++) begin
            // extremes first, then random settings
            case (pass)
                0:       begin mode = MODE_BARS;    width = 13'd2;    height = 13'd1;    end
                1:       begin mode = MODE_BLACK;   width = 13'd4096; height = 13'd4096; end
                2:       begin mode = MODE_WHITE;   width = 13'd0;    height = 13'd0;    end
                3:       begin mode = MODE_CHECKER; width = 13'd8191; height = 13'd8191; end
                4:       begin mode = MODE_BARS;    width = 13'd4096; height = 13'd4096; end
                5:       begin mode = MODE_BARS;    width = 13'd0;    height = 13'd8191; end
                6:       begin mode = MODE_BARS;    width = 13'd8191; height = 13'd0;    end
                default: begin
                    mode   = $urandom_range(0, 1) ? MODE_BARS : 2'($urandom_range(0, 3));
                    width  = pick_width();
                    height = pick_height();
                end
            endcase
            // upper data bits of the mode write are don't-care
            write_reg(REG_MODE, {11'($urandom_range(0, 2047)), mode});
            write_reg(REG_WIDTH, width);
            write_reg(REG_HEIGHT, height);
            @(posedge i_clk);

            if (pass == 1) begin
                // back-to-back pairs against a long output stall fill the block
                send_gap_max = 0;
                recv_gap_max = 5;
                hold_armed   = 1'b1;
            end else begin
                send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
                recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            end
            for (int n = 0; n < WORDS_PER_PASS; n++) begin
                queue_random_pair();
            end
            wait_for_drain();
        end

        if (mismatch_count == 0) begin
            $display("** uyvy_test_pattern_generator: PASSED **");
        end else begin
            $display("** uyvy_test_pattern_generator: FAILED **");
        end
        $finish;
    end

endmodule
